// ===== hdl/utf8_stream_decoder_assert.svh =====
// Assertion macros shared by the UTF-8 stream decoder RTL.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define UTF8SD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8 decoder assertion failed");
`define UTF8SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8 decoder assertion failed");
`else
`define UTF8SD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define UTF8SD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/utf8sd_pkg.sv =====
// Types, constants and helper functions of the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package utf8sd_pkg;

   localparam int CpWidth  = 21;
   localparam int LenWidth = 4;

   localparam logic [7:0] CONT_MASK      = 8'hC0;
   localparam logic [7:0] CONT_TAG       = 8'h80;
   localparam logic [7:0] TRAIL_PAYLOAD  = 8'h3F;
   localparam logic [7:0] OVERLONG2_MASK = 8'hFE;
   localparam logic [7:0] OVERLONG2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD_E0_BYTE   = 8'hE0;
   localparam logic [7:0] LEAD_F0_BYTE   = 8'hF0;
   localparam logic [7:0] E0_TRAIL_MASK  = 8'hE0;
   localparam logic [7:0] F0_TRAIL_MASK  = 8'hF0;
   localparam logic [3:0] MAX_VALID_LEN  = 4'd4;

   typedef enum logic [1:0] {
      LEAD_OTHER = 2'd0,
      LEAD_E0    = 2'd1,
      LEAD_F0    = 2'd2
   } lead_kind_type;

   typedef struct packed {
      logic [2:0]          bytes_left;
      logic [CpWidth-1:0]  accumulator;
      logic                bad_so_far;
      lead_kind_type       lead_kind;
      logic                first_trail_pending;
      logic [LenWidth-1:0] length_seen;
   } state_type;

   typedef struct packed {
      logic [CpWidth-1:0]  code_point;
      logic                malformed;
      logic [LenWidth-1:0] item_length;
   } result_type;

   // Number of leading one bits of a byte, 0 to 8.
   function automatic logic [3:0] leading_ones(input logic [7:0] b);
      logic [3:0] n;
      if (!b[7]) begin
         n = 4'd0;
      end else if (!b[6]) begin
         n = 4'd1;
      end else if (!b[5]) begin
         n = 4'd2;
      end else if (!b[4]) begin
         n = 4'd3;
      end else if (!b[3]) begin
         n = 4'd4;
      end else if (!b[2]) begin
         n = 4'd5;
      end else if (!b[1]) begin
         n = 4'd6;
      end else if (!b[0]) begin
         n = 4'd7;
      end else begin
         n = 4'd8;
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/utf8sd_step.sv =====
// Per-word decode step: next decoder state and the result of one byte.
`timescale 1ns / 1ps
`default_nettype none
module utf8sd_step (
   input  wire logic [7:0]           in_byte,
   input  wire utf8sd_pkg::state_type cur_state,
   output utf8sd_pkg::state_type     next_state,
   output logic                      emit,
   output utf8sd_pkg::result_type    result
);

   logic [3:0] lead_len;
   logic [2:0] left_after;
   logic       bad_now;

   assign lead_len   = utf8sd_pkg::leading_ones(in_byte);
   assign left_after = cur_state.bytes_left - 3'd1;

   always_comb begin
      next_state = cur_state;
      emit       = 1'b0;
      result     = '0;
      bad_now    = cur_state.bad_so_far;
      if (cur_state.bytes_left == 3'd0) begin
         if (!in_byte[7] || (in_byte & utf8sd_pkg::CONT_MASK) == utf8sd_pkg::CONT_TAG) begin
            // ASCII or a stray continuation word passes through as itself.
            emit               = 1'b1;
            result.code_point  = {13'd0, in_byte};
            result.malformed   = 1'b0;
            result.item_length = 4'd1;
         end else begin
            next_state.accumulator = '0;
            next_state.bad_so_far  = 1'b0;
            next_state.lead_kind   = utf8sd_pkg::LEAD_OTHER;
            if (lead_len > utf8sd_pkg::MAX_VALID_LEN) begin
               next_state.bad_so_far = 1'b1;
            end else begin
               case (lead_len)
                  4'd2:    next_state.accumulator = {16'd0, in_byte[4:0]};
                  4'd3:    next_state.accumulator = {17'd0, in_byte[3:0]};
                  default: next_state.accumulator = {18'd0, in_byte[2:0]};
               endcase
               if ((in_byte & utf8sd_pkg::OVERLONG2_MASK) == utf8sd_pkg::OVERLONG2_TAG) begin
                  next_state.bad_so_far = 1'b1;
               end else if (in_byte == utf8sd_pkg::LEAD_E0_BYTE) begin
                  next_state.lead_kind = utf8sd_pkg::LEAD_E0;
               end else if (in_byte == utf8sd_pkg::LEAD_F0_BYTE) begin
                  next_state.lead_kind = utf8sd_pkg::LEAD_F0;
               end
            end
            // An eight-byte lead wraps to seven trailing words.
            next_state.bytes_left          = lead_len[2:0] - 3'd1;
            next_state.length_seen         = lead_len;
            next_state.first_trail_pending = 1'b1;
         end
      end else begin
         if (cur_state.first_trail_pending) begin
            case (cur_state.lead_kind)
               utf8sd_pkg::LEAD_E0: begin
                  if ((in_byte & utf8sd_pkg::E0_TRAIL_MASK) == utf8sd_pkg::CONT_TAG)
                     bad_now = 1'b1;
               end
               utf8sd_pkg::LEAD_F0: begin
                  if ((in_byte & utf8sd_pkg::F0_TRAIL_MASK) == utf8sd_pkg::CONT_TAG)
                     bad_now = 1'b1;
               end
               default: ;
            endcase
         end
         if ((in_byte & utf8sd_pkg::CONT_MASK) != utf8sd_pkg::CONT_TAG)
            bad_now = 1'b1;
         next_state.first_trail_pending = 1'b0;
         next_state.bad_so_far          = bad_now;
         next_state.accumulator         = {cur_state.accumulator[14:0],
                                           in_byte[5:0] & utf8sd_pkg::TRAIL_PAYLOAD[5:0]};
         next_state.bytes_left          = left_after;
         if (left_after == 3'd0) begin
            emit               = 1'b1;
            result.code_point  = bad_now ? '0 : next_state.accumulator;
            result.malformed   = bad_now;
            result.item_length = cur_state.length_seen;
            next_state         = '0;
         end
      end
   end

endmodule
`default_nettype wire

// ===== hdl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder with its handshake and result register.
`timescale 1ns / 1ps
`default_nettype none
// Decodes a UTF-8 stream at one byte per clock while rsp_ready does not stall it.
// Each accepted word updates the item state; when the last byte of an item is taken,
// the code point, malformed flag and item length appear in the result register on the
// next cycle. The input stays ready while the result register is empty or being
// drained, so with rsp_ready held high one byte is taken every cycle.
// Malformed items (overlong, bad trailing byte, or longer than four bytes) report
// code point zero; stray continuation bytes pass through as length-one items.
`include "utf8_stream_decoder_assert.svh"
module utf8_stream_decoder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_in_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [utf8sd_pkg::CpWidth-1:0]      rsp_code_point,
   output logic                                rsp_malformed,
   output logic [utf8sd_pkg::LenWidth-1:0]     rsp_item_length
);

   utf8sd_pkg::state_type  state_ff;
   utf8sd_pkg::state_type  state_in;
   utf8sd_pkg::result_type result_ff;
   utf8sd_pkg::result_type result_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   emit;
   logic                   req_fire;

   utf8sd_step u_step (
      .in_byte    (req_in_byte),
      .cur_state  (state_ff),
      .next_state (state_in),
      .emit       (emit),
      .result     (result_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_fire && emit)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire)
            state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit)
         result_ff <= result_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_point  = result_ff.code_point;
   assign rsp_malformed   = result_ff.malformed;
   assign rsp_item_length = result_ff.item_length;

   // An open item always comes from a lead of two or more bytes.
   `UTF8SD_ASSERT_IMPL(a_open_len, clock, reset,
      state_ff.bytes_left != 3'd0, state_ff.length_seen >= 4'd2)
   // The first-trail flag is only set while trailing words are expected.
   `UTF8SD_ASSERT_IMPL(a_first_open, clock, reset,
      state_ff.first_trail_pending, state_ff.bytes_left != 3'd0)
   // A rejected item never carries a code point.
   `UTF8SD_ASSERT_IMPL(a_bad_zero, clock, reset,
      rsp_valid && rsp_malformed, rsp_code_point == '0)
   // Items longer than four bytes are always rejected.
   `UTF8SD_ASSERT_IMPL(a_long_bad, clock, reset,
      rsp_valid && rsp_item_length > 4'd4, rsp_malformed)
   // A word that closes an item while the output is free shows up next cycle.
   `UTF8SD_ASSERT_NEXT(a_emit_shows, clock, reset,
      req_fire && emit, rsp_valid)

endmodule
`default_nettype wire

// ===== sim/utf8_stream_decoder_test.sv =====
// Self-checking testbench for the UTF-8 stream decoder with a built-in decode predictor.
`timescale 1ns / 1ps
module utf8_stream_decoder_test;

   localparam int RANDOM_BYTES = 2000;
   localparam int CYCLE_LIMIT  = 1000000;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [7:0]                      req_in_byte;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [utf8sd_pkg::CpWidth-1:0]  rsp_code_point;
   logic                            rsp_malformed;
   logic [utf8sd_pkg::LenWidth-1:0] rsp_item_length;

   utf8_stream_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_malformed  (rsp_malformed),
      .rsp_item_length(rsp_item_length)
   );

   typedef struct {
      logic [7:0]             data;
      bit                     typed;
      utf8sd_pkg::result_type want;
   } stim_row_type;

   stim_row_type           directed_rows[$];
   utf8sd_pkg::result_type code_points_due[$];

   // Predictor state for the item being decoded.
   logic [2:0]                      trail_left;
   logic [utf8sd_pkg::CpWidth-1:0]  cp_acc;
   logic                            item_bad;
   utf8sd_pkg::lead_kind_type       lead_sel;
   logic                            first_trail;
   logic [utf8sd_pkg::LenWidth-1:0] item_len;

   int bytes_sent;
   int items_decoded   = 0;
   int malformed_items = 0;
   int failures        = 0;
   int cycle_count     = 0;
   bit calm;

   always #4 clock = ~clock;

   function automatic void clear_item();
      trail_left  = '0;
      cp_acc      = '0;
      item_bad    = 1'b0;
      lead_sel    = utf8sd_pkg::LEAD_OTHER;
      first_trail = 1'b0;
      item_len    = '0;
   endfunction

   // Returns 1 when the word completes an item, with the decoded result in res.
   function automatic bit decode_byte(input logic [7:0] b,
                                      output utf8sd_pkg::result_type res);
      int ones;
      res = '0;
      if (trail_left == 3'd0) begin
         if (b[7] == 1'b0 || b[7:6] == 2'b10) begin
            res.code_point  = {13'd0, b};
            res.item_length = 4'd1;
            return 1'b1;
         end
         ones = 0;
         while (ones < 8 && b[7 - ones]) ones++;
         cp_acc   = '0;
         item_bad = 1'b0;
         lead_sel = utf8sd_pkg::LEAD_OTHER;
         if (ones > 4) begin
            item_bad = 1'b1;
         end else begin
            cp_acc = {13'd0, b & (8'hFF >> (ones + 1))};
            if (b[7:1] == 7'b1100000) begin
               item_bad = 1'b1;
            end else if (b == 8'hE0) begin
               lead_sel = utf8sd_pkg::LEAD_E0;
            end else if (b == 8'hF0) begin
               lead_sel = utf8sd_pkg::LEAD_F0;
            end
         end
         trail_left  = 3'(ones - 1);
         item_len    = utf8sd_pkg::LenWidth'(ones);
         first_trail = 1'b1;
         return 1'b0;
      end
      // The first trailing word after E0 or F0 decides whether the item is overlong.
      if (first_trail) begin
         if (lead_sel == utf8sd_pkg::LEAD_E0 && b[7:5] == 3'b100) item_bad = 1'b1;
         if (lead_sel == utf8sd_pkg::LEAD_F0 && b[7:4] == 4'b1000) item_bad = 1'b1;
         first_trail = 1'b0;
      end
      if (b[7:6] != 2'b10) item_bad = 1'b1;
      cp_acc     = {cp_acc[utf8sd_pkg::CpWidth-7:0], b[5:0]};
      trail_left = trail_left - 3'd1;
      if (trail_left != 3'd0) return 1'b0;
      res.code_point  = item_bad ? '0 : cp_acc;
      res.malformed   = item_bad;
      res.item_length = item_len;
      clear_item();
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] trail_byte();
      return {2'b10, 6'($urandom_range(0, 63))};
   endfunction

   function automatic void add_row(input logic [7:0] data, input bit typed = 1'b0,
                                   input logic [utf8sd_pkg::CpWidth-1:0] cp = '0,
                                   input logic bad = 1'b0,
                                   input logic [utf8sd_pkg::LenWidth-1:0] len = '0);
      stim_row_type row;
      row.data                 = data;
      row.typed                = typed;
      row.want.code_point      = cp;
      row.want.malformed       = bad;
      row.want.item_length     = len;
      directed_rows.push_back(row);
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input utf8sd_pkg::result_type want = '0);
      int gap;
      utf8sd_pkg::result_type res;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (decode_byte(b, res) && !typed) code_points_due.push_back(res);
      if (typed) code_points_due.push_back(want);
   endtask

   // Mostly well-formed sequences with random payload, plus overlong, broken,
   // long-lead and noise items.
   task automatic send_random_item();
      int kind, len, bad_at, r, i;
      logic [7:0] lead;
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
         send_byte(8'($urandom_range(0, 127)));
      end else if (kind < 38) begin
         send_byte(8'($urandom_range(8'hC2, 8'hDF)));
         send_byte(trail_byte());
      end else if (kind < 56) begin
         lead = 8'($urandom_range(8'hE0, 8'hEF));
         send_byte(lead);
         send_byte(lead == 8'hE0 ? 8'($urandom_range(8'hA0, 8'hBF)) : trail_byte());
         send_byte(trail_byte());
      end else if (kind < 72) begin
         lead = 8'($urandom_range(8'hF0, 8'hF7));
         send_byte(lead);
         send_byte(lead == 8'hF0 ? 8'($urandom_range(8'h90, 8'hBF)) : trail_byte());
         send_byte(trail_byte());
         send_byte(trail_byte());
      end else if (kind < 78) begin
         send_byte(trail_byte());
      end else if (kind < 84) begin
         r = $urandom_range(0, 2);
         case (r)
            0: begin
               send_byte(8'hC0 | 8'($urandom_range(0, 1)));
               send_byte(trail_byte());
            end
            1: begin
               send_byte(8'hE0);
               send_byte(8'($urandom_range(8'h80, 8'h9F)));
               send_byte(trail_byte());
            end
            default: begin
               send_byte(8'hF0);
               send_byte(8'($urandom_range(8'h80, 8'h8F)));
               send_byte(trail_byte());
               send_byte(trail_byte());
            end
         endcase
      end else if (kind < 90) begin
         lead   = 8'($urandom_range(8'hC2, 8'hF7));
         len    = lead < 8'hE0 ? 2 : (lead < 8'hF0 ? 3 : 4);
         bad_at = $urandom_range(1, len - 1);
         send_byte(lead);
         for (i = 1; i < len; i++)
            send_byte(i == bad_at ? 8'($urandom_range(0, 255)) : trail_byte());
      end else if (kind < 95) begin
         lead = 8'($urandom_range(8'hF8, 8'hFF));
         len  = 5 + int'(lead >= 8'hFC) + int'(lead >= 8'hFE) + int'(lead == 8'hFF);
         send_byte(lead);
         repeat (len - 1) send_byte(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, code_points_due.size());
         $display("utf8_stream_decoder_test: errors");
         $finish;
      end
   end

   // Result side: stalls of random length; no new stall starts while the stimulus is calm.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : check_results
      utf8sd_pkg::result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (code_points_due.size() == 0) begin
            $display("%0t: unexpected result: code_point %h malformed %b length %0d",
                     $time, rsp_code_point, rsp_malformed, rsp_item_length);
            failures++;
         end else begin
            due = code_points_due.pop_front();
            if (rsp_code_point !== due.code_point) begin
               $display("%0t: code_point expected %h, got %h",
                        $time, due.code_point, rsp_code_point);
               failures++;
            end
            if (rsp_malformed !== due.malformed) begin
               $display("%0t: malformed expected %b, got %b",
                        $time, due.malformed, rsp_malformed);
               failures++;
            end
            if (rsp_item_length !== due.item_length) begin
               $display("%0t: item_length expected %0d, got %0d",
                        $time, due.item_length, rsp_item_length);
               failures++;
            end
            items_decoded++;
            if (due.malformed) malformed_items++;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_in_byte     = 8'h00;
      bytes_sent      = 0;
      calm            = 1'b0;
      clear_item();

      add_row(8'h00, 1'b1, 21'h0, 1'b0, 4'd1);
      add_row(8'h80, 1'b1, 21'h80, 1'b0, 4'd1);   // stray continuation word
      add_row(8'hC0);                             // overlong two-word lead
      add_row(8'hBF, 1'b1, 21'h0, 1'b1, 4'd2);
      add_row(8'hE0);                             // overlong three-word form
      add_row(8'h9F);
      add_row(8'hBF, 1'b1, 21'h0, 1'b1, 4'd3);
      add_row(8'hF0);                             // overlong four-word form
      add_row(8'h8F);
      add_row(8'hBF);
      add_row(8'hBF, 1'b1, 21'h0, 1'b1, 4'd4);
      add_row(8'hF7);                             // largest code point, no range check
      add_row(8'hBF);
      add_row(8'hBF);
      add_row(8'hBF);
      add_row(8'hC3);                             // bad trailing word is still consumed
      add_row(8'h7F, 1'b1, 21'h0, 1'b1, 4'd2);
      add_row(8'hFF);                             // eight-word lead
      add_row(8'h80);
      add_row(8'hBF);
      add_row(8'h80);
      add_row(8'hBF);
      add_row(8'h80);
      add_row(8'hBF);
      add_row(8'h80, 1'b1, 21'h0, 1'b1, 4'd8);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

      while (bytes_sent < RANDOM_BYTES + directed_rows.size()) begin
         calm = ((bytes_sent / 160) % 6) == 4;
         send_random_item();
      end
      req_valid <= 1'b0;

      while (code_points_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Decoded %0d bytes (%0d directed) into %0d checked items, %0d malformed.",
               bytes_sent, directed_rows.size(), items_decoded, malformed_items);
      $display("Covered ASCII, two- to four-word forms, stray, overlong, broken and long leads.");
      if (failures == 0 && code_points_due.size() == 0) begin
         $display("utf8_stream_decoder_test: clean");
      end else begin
         $display("utf8_stream_decoder_test: errors");
      end
      $finish;
   end

endmodule
